/* rtl/bsfd_pkg.sv */
package bsfd_pkg;

    // Frame buffer geometry
    localparam int MAX_FRAME = 32;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int BYTE_W    = 8;

    // Output field widths
    localparam int IDX_W = 5;
    localparam int LEN_W = 6;

    // Link control bytes
    localparam logic [BYTE_W-1:0] FLAG_START = 8'h12;
    localparam logic [BYTE_W-1:0] FLAG_END   = 8'h13;
    localparam logic [BYTE_W-1:0] FLAG_ESC   = 8'h7D;

    // Decoder mode
    typedef enum logic [1:0] {
        MODE_WAIT    = 2'd0,
        MODE_BODY    = 2'd1,
        MODE_ESCAPED = 2'd2
    } t_mode;

    // Control sequencer: taking link bytes or playing out a frame
    typedef enum logic {
        ST_IN  = 1'b0,
        ST_OUT = 1'b1
    } t_state;

endpackage

/* rtl/bsfd_ram.sv */
module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/byte_stuffed_frame_decoder.sv */
// Byte-stuffed frame decoder. Takes one raw link byte per request and strips
// the framing: start flag 0x12, end flag 0x13, escape 0x7D (only a flag byte
// may follow an escape). Bytes of the open frame go into a 32-entry buffer
// RAM. On the end flag the decoder stops taking bytes and plays the frame
// out of the RAM, one result per cycle while the sink is ready, each with its
// index, the frame length and a last mark; an empty frame gives a single
// result flagged empty. The first result appears in the cycle after the end
// flag is taken (RAM read register), and link input resumes the cycle after
// the last result is taken. Aborted frames (bad escape, start flag inside a
// frame, buffer overflow) give no result.
module byte_stuffed_frame_decoder
    import bsfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_data_byte,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_is_last,
    output logic              o_is_empty
);

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic               r_empty, n_empty;

    logic               in_acc, out_acc;
    logic               is_flag;
    logic               last_byte;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    // Frame buffer
    bsfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_ready = (r_state == ST_IN);
    assign o_valid = (r_state == ST_OUT);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign is_flag   = (i_in_byte == FLAG_START) || (i_in_byte == FLAG_END)
                    || (i_in_byte == FLAG_ESC);
    assign last_byte = (CNT_W'({1'b0, r_idx}) + CNT_W'(1)) == r_fill;

    // Result fields come straight from the RAM read register and counters
    assign o_data_byte    = r_empty ? '0 : mem_rdata;
    assign o_byte_index   = IDX_W'(r_idx);
    assign o_frame_length = LEN_W'(r_fill);
    assign o_is_last      = r_empty || last_byte;
    assign o_is_empty     = r_empty;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IN;
            r_mode  <= MODE_WAIT;
            r_fill  <= '0;
            r_idx   <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_empty <= n_empty;
        end
    end

    // Decode and playout sequencing
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_empty   = r_empty;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            ST_IN: begin
                if (in_acc) begin
                    unique case (r_mode)
                        MODE_WAIT: begin
                            if (i_in_byte == FLAG_START) begin
                                n_fill = '0;
                                n_mode = MODE_BODY;
                            end
                        end
                        MODE_BODY: begin
                            if (i_in_byte == FLAG_ESC) begin
                                n_mode = MODE_ESCAPED;
                            end else if (i_in_byte == FLAG_END) begin
                                // close frame: prefetch entry 0 and play out
                                n_mode    = MODE_WAIT;
                                n_state   = ST_OUT;
                                n_idx     = '0;
                                n_empty   = (r_fill == '0);
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end else if (i_in_byte == FLAG_START) begin
                                n_mode = MODE_WAIT;
                            end else if (r_fill == CNT_W'(MAX_FRAME)) begin
                                n_mode = MODE_WAIT;
                            end else begin
                                mem_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        MODE_ESCAPED: begin
                            if (!is_flag || r_fill == CNT_W'(MAX_FRAME)) begin
                                n_mode = MODE_WAIT;
                            end else begin
                                mem_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                                n_mode = MODE_BODY;
                            end
                        end
                        default: begin
                            n_mode = MODE_WAIT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                // next entry is read on the same edge the current result leaves
                if (out_acc) begin
                    if (o_is_last) begin
                        n_state = ST_IN;
                        n_empty = 1'b0;
                    end else begin
                        n_idx     = r_idx + ADDR_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    // Input is held off for the whole playout
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken during frame playout");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_is_last && o_frame_length == '0
                                     && o_data_byte == '0))
        else $error("malformed empty-frame result");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_empty) |-> ({1'b0, o_byte_index} < o_frame_length))
        else $error("byte index beyond frame length");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_is_last) |=> (!o_valid && o_ready))
        else $error("playout did not end after last result");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_is_last) |=> (o_valid
                                     && o_byte_index == $past(o_byte_index) + 5'd1))
        else $error("playout index did not advance");

endmodule
